### rtl/core/rcpe_pkg.sv
// Package with coefficient tables and helper functions for the power estimator.
`timescale 1ns / 1ps
`default_nettype none
package rcpe_pkg;

    localparam int NUM_SETS = 3;
    localparam int TABLE_POINTS = 15;

    typedef logic signed [11:0] temp_t;
    typedef logic [15:0] dens_t;

    localparam logic [1:0] REF_R290  = 2'd0;
    localparam logic [1:0] REF_R32   = 2'd1;
    localparam logic [1:0] REF_R410A = 2'd2;

    typedef struct packed {
        logic signed [15:0] ev_a;
        logic signed [15:0] ev_b;
        logic signed [15:0] ev_c;
        logic signed [15:0] cd_a;
        logic signed [15:0] cd_b;
        logic signed [15:0] cd_c;
        logic signed [15:0] cp_b;
        logic signed [15:0] cp_c;
        logic signed [15:0] ds_a;
        logic signed [15:0] ds_b;
        logic signed [15:0] ds_c;
    } fit_t;

    localparam fit_t FIT_R290 = '{16'sd3808, 16'sd975, -16'sd2945, 16'sd3874, -16'sd752,
        -16'sd1482, -16'sd1766, 16'sd1588, 16'sd64, -16'sd38, 16'sd119};
    localparam fit_t FIT_R32 = '{16'sd3160, 16'sd48, -16'sd1993, 16'sd3170, -16'sd1698,
        -16'sd468, -16'sd1755, 16'sd1548, 16'sd75, -16'sd139, 16'sd196};
    localparam fit_t FIT_R410A = '{16'sd2220, 16'sd222, -16'sd1705, 16'sd2230, -16'sd941,
        -16'sd687, -16'sd1175, 16'sd1047, 16'sd608, -16'sd77, 16'sd154};

    localparam logic signed [15:0] TEMP_R290 [TABLE_POINTS] = '{-16'sd400, -16'sd302,
        -16'sd205, -16'sd107, -16'sd9, 16'sd88, 16'sd186, 16'sd284, 16'sd381, 16'sd479,
        16'sd577, 16'sd674, 16'sd772, 16'sd870, 16'sd967};
    localparam logic [15:0] DENS_R290 [TABLE_POINTS] = '{16'd26, 16'd38, 16'd54, 16'd75,
        16'd101, 16'd133, 16'd174, 16'd225, 16'd288, 16'd367, 16'd467, 16'd598, 16'd778,
        16'd1058, 16'd2205};
    localparam logic signed [15:0] TEMP_R32 [TABLE_POINTS] = '{-16'sd400, -16'sd316,
        -16'sd231, -16'sd147, -16'sd63, 16'sd22, 16'sd106, 16'sd191, 16'sd275, 16'sd359,
        16'sd444, 16'sd528, 16'sd612, 16'sd697, 16'sd781};
    localparam logic [15:0] DENS_R32 [TABLE_POINTS] = '{16'd51, 16'd72, 16'd99, 16'd135,
        16'd180, 16'd237, 16'd308, 16'd397, 16'd509, 16'd651, 16'd833, 16'd1074, 16'd1410,
        16'd1939, 16'd4240};
    localparam logic signed [15:0] TEMP_R410A [TABLE_POINTS] = '{-16'sd400, -16'sd320,
        -16'sd241, -16'sd161, -16'sd82, -16'sd2, 16'sd77, 16'sd157, 16'sd236, 16'sd316,
        16'sd395, 16'sd475, 16'sd554, 16'sd634, 16'sd713};
    localparam logic [15:0] DENS_R410A [TABLE_POINTS] = '{16'd70, 16'd97, 16'd132, 16'd177,
        16'd233, 16'd303, 16'd390, 16'd498, 16'd633, 16'd802, 16'd1018, 16'd1302, 16'd1696,
        16'd2317, 16'd4605};

    // Per segment, ceil(2^25 / span); exact for interpolation products below 2^18.
    localparam logic [18:0] RECIP_R290 [TABLE_POINTS] = '{19'd342393, 19'd345922,
        19'd342393, 19'd342393, 19'd345922, 19'd342393, 19'd342393, 19'd345922, 19'd342393,
        19'd342393, 19'd345922, 19'd342393, 19'd342393, 19'd345922, 19'd0};
    localparam logic [18:0] RECIP_R32 [TABLE_POINTS] = '{19'd399458, 19'd394759,
        19'd399458, 19'd399458, 19'd394759, 19'd399458, 19'd394759, 19'd399458, 19'd399458,
        19'd394759, 19'd399458, 19'd399458, 19'd394759, 19'd399458, 19'd0};
    localparam logic [18:0] RECIP_R410A [TABLE_POINTS] = '{19'd419431, 19'd424740,
        19'd419431, 19'd424740, 19'd419431, 19'd424740, 19'd419431, 19'd424740, 19'd419431,
        19'd424740, 19'd419431, 19'd424740, 19'd419431, 19'd424740, 19'd0};

    // Reciprocals for truncating division by constants.
    localparam logic [23:0] RECIP_100 = 24'd10737419;        // ceil(2^30 / 100)
    localparam logic [23:0] RECIP_1000 = 24'd8589935;        // ceil(2^33 / 1000)
    localparam logic [26:0] RECIP_1000_WIDE = 27'd68719477;  // ceil(2^36 / 1000)
    localparam logic [31:0] DIV_100_SAT = 32'd6553600;
    localparam logic [31:0] DIV_1000_SAT = 32'd65536000;

    function automatic fit_t fit_of(input logic [1:0] sel);
        fit_t f;
        unique case (sel)
            REF_R290: f = FIT_R290;
            REF_R32:  f = FIT_R32;
            default:  f = FIT_R410A;
        endcase
        return f;
    endfunction

    // Table point lookup; points beyond the built-in table repeat the last one.
    function automatic logic signed [15:0] temp_at(input logic [1:0] sel, input int i);
        int j;
        logic signed [15:0] v;
        j = (i > TABLE_POINTS - 1) ? TABLE_POINTS - 1 : i;
        unique case (sel)
            REF_R290: v = TEMP_R290[j];
            REF_R32:  v = TEMP_R32[j];
            default:  v = TEMP_R410A[j];
        endcase
        return v;
    endfunction

    function automatic logic [15:0] dens_at(input logic [1:0] sel, input int i);
        int j;
        logic [15:0] v;
        j = (i > TABLE_POINTS - 1) ? TABLE_POINTS - 1 : i;
        unique case (sel)
            REF_R290: v = DENS_R290[j];
            REF_R32:  v = DENS_R32[j];
            default:  v = DENS_R410A[j];
        endcase
        return v;
    endfunction

    function automatic logic [18:0] recip_at(input logic [1:0] sel, input int i);
        int j;
        logic [18:0] v;
        j = (i > TABLE_POINTS - 1) ? TABLE_POINTS - 1 : i;
        unique case (sel)
            REF_R290: v = RECIP_R290[j];
            REF_R32:  v = RECIP_R32[j];
            default:  v = RECIP_R410A[j];
        endcase
        return v;
    endfunction

    // Truncating signed divide by 1000 for magnitudes below 2^23.
    function automatic logic signed [15:0] sdiv_1000(input logic signed [27:0] x);
        logic [22:0] a;
        logic [46:0] p;
        logic [15:0] q;
        a = x[27] ? 23'(-x) : 23'(x);
        p = 47'(a) * 47'(RECIP_1000);
        q = 16'(p[46:33]);
        return x[27] ? -signed'(q) : signed'(q);
    endfunction

    // Truncating signed divide by 100 for magnitudes below 2^23.
    function automatic logic signed [15:0] sdiv_100(input logic signed [27:0] x);
        logic [22:0] a;
        logic [46:0] p;
        logic [15:0] q;
        a = x[27] ? 23'(-x) : 23'(x);
        p = 47'(a) * 47'(RECIP_100);
        q = p[45:30];
        return x[27] ? -signed'(q) : signed'(q);
    endfunction

    // Unsigned divide by 100, saturated at 65535.
    function automatic logic [15:0] udiv_100_sat(input logic [31:0] n);
        logic [46:0] p;
        p = 47'(n[22:0]) * 47'(RECIP_100);
        return (n >= DIV_100_SAT) ? 16'hFFFF : p[45:30];
    endfunction

    // Unsigned divide by 1000, saturated at 65535.
    function automatic logic [15:0] udiv_1000_sat(input logic [31:0] n);
        logic [52:0] p;
        p = 53'(n[25:0]) * 53'(RECIP_1000_WIDE);
        return (n >= DIV_1000_SAT) ? 16'hFFFF : p[51:36];
    endfunction

endpackage
`default_nettype wire

### rtl/core/refrigerant_cycle_power_estimator.sv
// Top level of the refrigerant cycle power estimator pipeline.
//
// Usage: input beats on s_axis carry one sample of displacement, speed and the
// evaporating and condensing temperatures. Each beat yields one output beat on
// m_axis with the mass flow, the three powers and the discharge target.
// The refrigerant register selects the coefficient set; the user must write it through
// cfg_we and cfg_data only while the pipeline is empty; the block does not enforce this.
// The pipeline has seven register stages: the input products and table search,
// the constant divisions, density and enthalpy sums, the mass product, the mass
// division, the power products and the power divisions. One beat can enter every
// cycle while m_axis_tready is high or the last stage holds no result.
// Reset clears all valid bits and sets the refrigerant to R290.
// When the receiver deasserts m_axis_tready while a result waits, every stage
// holds its contents and s_axis_tready falls, so no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module refrigerant_cycle_power_estimator
    import rcpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // displacement[15:0], speed[31:16], evap_temp[43:32], cond_temp[55:44]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mass_flow, evap_power, cond_power, comp_power, discharge_target from bit 0
    output logic [79:0]      m_axis_tdata
);

    localparam int IW = $clog2(TABLE_POINTS);
    localparam int STAGES = 7;

    logic [1:0] refrigerant_reg;
    logic       adv;
    logic [STAGES-1:0] v_reg;

    assign adv = m_axis_tready || !v_reg[STAGES-1];
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refrigerant_reg <= REF_R290;
            v_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                refrigerant_reg <= cfg_data;
            if (adv)
                v_reg <= {v_reg[STAGES-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: product, segment search, fit products.
    logic [31:0] prod1_reg;
    logic signed [11:0] te1_reg;
    logic [IW-1:0] seg1_reg;
    logic lo1_reg, hi1_reg;
    logic signed [27:0] p1_reg [8];
    logic [1:0] sel1_reg;
    fit_t f0;
    logic signed [11:0] te0, tc0;
    logic [IW-1:0] seg0;
    assign te0 = s_axis_tdata[43:32];
    assign tc0 = s_axis_tdata[55:44];
    assign f0 = fit_of(refrigerant_reg);

    always_comb
    begin
        seg0 = '0;
        for (int i = 1; i < TABLE_POINTS; i++)
            if (16'(te0) >= temp_at(refrigerant_reg, i))
                seg0 = IW'(i);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod1_reg <= 32'(s_axis_tdata[15:0]) * 32'(s_axis_tdata[31:16]);
            te1_reg <= te0;
            sel1_reg <= refrigerant_reg;
            seg1_reg <= seg0;
            lo1_reg <= (16'(te0) <= temp_at(refrigerant_reg, 0));
            hi1_reg <= (16'(te0) >= temp_at(refrigerant_reg, TABLE_POINTS - 1));
            p1_reg[0] <= 28'(f0.ev_b) * 28'(te0);
            p1_reg[1] <= 28'(f0.ev_c) * 28'(tc0);
            p1_reg[2] <= 28'(f0.cd_b) * 28'(te0);
            p1_reg[3] <= 28'(f0.cd_c) * 28'(tc0);
            p1_reg[4] <= 28'(f0.cp_b) * 28'(te0);
            p1_reg[5] <= 28'(f0.cp_c) * 28'(tc0);
            p1_reg[6] <= 28'(f0.ds_b) * 28'(te0);
            p1_reg[7] <= 28'(f0.ds_c) * 28'(tc0);
        end
    end

    // Stage 2: volume, interpolation product, fit quotients.
    logic [15:0] vol2_reg;
    logic [17:0] ip2_reg;
    logic [18:0] recip2_reg;
    logic [15:0] d1_2_reg;
    logic lo2_reg, hi2_reg;
    logic signed [15:0] q2_reg [8];
    logic [1:0] sel2_reg;
    logic signed [15:0] t1s;
    logic [15:0] d1s, d2s;
    logic [6:0] dt1;
    logic [11:0] dd1;
    assign t1s = temp_at(sel1_reg, int'(seg1_reg));
    assign d1s = dens_at(sel1_reg, int'(seg1_reg));
    assign d2s = dens_at(sel1_reg, int'(seg1_reg) + 1);
    assign dt1 = 7'(16'(te1_reg) - t1s);
    assign dd1 = 12'(d2s - d1s);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vol2_reg <= udiv_100_sat(prod1_reg);
            ip2_reg <= 18'(19'(dt1) * 19'(dd1));
            recip2_reg <= recip_at(sel1_reg, int'(seg1_reg));
            d1_2_reg <= d1s;
            lo2_reg <= lo1_reg;
            hi2_reg <= hi1_reg;
            sel2_reg <= sel1_reg;
            for (int k = 0; k < 6; k++)
                q2_reg[k] <= sdiv_1000(p1_reg[k]);
            q2_reg[6] <= sdiv_100(p1_reg[6]);
            q2_reg[7] <= sdiv_100(p1_reg[7]);
        end
    end

    // Stage 3: density, enthalpy deltas, discharge target.
    logic [15:0] vol3_reg, dens3_reg;
    logic [15:0] dh3_reg [3];
    logic [15:0] ds3_reg;
    fit_t f2;
    logic signed [17:0] dsum [3];
    logic signed [17:0] dss;
    logic [36:0] ipm;
    logic [15:0] dv;
    assign f2 = fit_of(sel2_reg);
    assign dsum[0] = 18'(f2.ev_a) + 18'(q2_reg[0]) + 18'(q2_reg[1]);
    assign dsum[1] = 18'(f2.cd_a) + 18'(q2_reg[2]) + 18'(q2_reg[3]);
    assign dsum[2] = 18'(q2_reg[4]) + 18'(q2_reg[5]);
    assign dss = 18'(f2.ds_a) + 18'(q2_reg[6]) + 18'(q2_reg[7]);
    assign ipm = 37'(ip2_reg) * 37'(recip2_reg);
    assign dv = d1_2_reg + 16'(ipm[36:25]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vol3_reg <= vol2_reg;
            dens3_reg <= lo2_reg ? dens_at(sel2_reg, 0)
                : hi2_reg ? dens_at(sel2_reg, TABLE_POINTS - 1) : dv;
            for (int k = 0; k < 3; k++)
                dh3_reg[k] <= (dsum[k] < 0) ? 16'd0
                    : (dsum[k] > 18'sd65535) ? 16'hFFFF : dsum[k][15:0];
            ds3_reg <= (dss > 18'sd32767) ? 16'h7FFF
                : (dss < -18'sd32768) ? 16'h8000 : dss[15:0];
        end
    end

    // Stage 4: mass product.
    logic [31:0] mp4_reg;
    logic [15:0] dh4_reg [3];
    logic [15:0] ds4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp4_reg <= 32'(vol3_reg) * 32'(dens3_reg);
            dh4_reg <= dh3_reg;
            ds4_reg <= ds3_reg;
        end
    end

    // Stage 5: mass flow.
    logic [15:0] m5_reg;
    logic [15:0] dh5_reg [3];
    logic [15:0] ds5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m5_reg <= udiv_1000_sat(mp4_reg);
            dh5_reg <= dh4_reg;
            ds5_reg <= ds4_reg;
        end
    end

    // Stage 6: power products.
    logic [31:0] pw6_reg [3];
    logic [15:0] m6_reg;
    logic [15:0] ds6_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                pw6_reg[k] <= 32'(m5_reg) * 32'(dh5_reg[k]);
            m6_reg <= m5_reg;
            ds6_reg <= ds5_reg;
        end
    end

    // Stage 7: powers.
    logic [79:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {ds6_reg, udiv_100_sat(pw6_reg[2]), udiv_100_sat(pw6_reg[1]),
                udiv_100_sat(pw6_reg[0]), m6_reg};
    end
    assign m_axis_tdata = out_reg;

endmodule
`default_nettype wire

### verif/refrigerant_cycle_power_estimator_test.sv
// Testbench for the refrigerant cycle power estimator: directed and random samples checked
// against an in-bench model of the estimate.
`timescale 1ns / 1ps
`default_nettype none
module refrigerant_cycle_power_estimator_test;
    import rcpe_pkg::*;

    typedef struct packed {
        logic signed [11:0] cond_temp;
        logic signed [11:0] evap_temp;
        logic [15:0] speed;
        logic [15:0] displacement;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] discharge_target;
        logic [15:0] comp_power;
        logic [15:0] cond_power;
        logic [15:0] evap_power;
        logic [15:0] mass_flow;
    } estimate_t;

    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_data = REF_R290;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    logic [1:0] refrigerant_sel = REF_R290;
    estimate_t expected_estimates[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit rx_steady = 1'b0;

    refrigerant_cycle_power_estimator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint suction_density(input logic [1:0] sel, input longint t);
        longint t1;
        longint t2;
        longint d1;
        longint d2;
        if (t <= temp_at(sel, 0))
            return dens_at(sel, 0);
        if (t >= temp_at(sel, TABLE_POINTS - 1))
            return dens_at(sel, TABLE_POINTS - 1);
        for (int i = 1; i < TABLE_POINTS; i++)
        begin
            if (t < temp_at(sel, i))
            begin
                t1 = temp_at(sel, i - 1);
                t2 = temp_at(sel, i);
                d1 = dens_at(sel, i - 1);
                d2 = dens_at(sel, i);
                return d1 + ((t - t1) * (d2 - d1)) / (t2 - t1);
            end
        end
        return dens_at(sel, TABLE_POINTS - 1);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic estimate_t predict_estimate(input sample_t s, input logic [1:0] sel);
        fit_t f;
        longint te;
        longint tc;
        longint vol;
        longint mass;
        longint dh_ev;
        longint dh_cd;
        longint dh_cp;
        estimate_t r;
        f = fit_of(sel);
        te = s.evap_temp;
        tc = s.cond_temp;
        vol = clip((longint'(s.displacement) * longint'(s.speed)) / 100, 0, 65535);
        mass = clip(vol * suction_density(sel, te) / 1000, 0, 65535);
        dh_ev = clip(f.ev_a + (f.ev_b * te) / 1000 + (f.ev_c * tc) / 1000, 0, 65535);
        dh_cd = clip(f.cd_a + (f.cd_b * te) / 1000 + (f.cd_c * tc) / 1000, 0, 65535);
        dh_cp = clip((f.cp_b * te) / 1000 + (f.cp_c * tc) / 1000, 0, 65535);
        r.mass_flow = 16'(mass);
        r.evap_power = 16'(clip(mass * dh_ev / 100, 0, 65535));
        r.cond_power = 16'(clip(mass * dh_cd / 100, 0, 65535));
        r.comp_power = 16'(clip(mass * dh_cp / 100, 0, 65535));
        r.discharge_target = 16'(clip(f.ds_a + (f.ds_b * te) / 100 + (f.ds_c * tc) / 100,
            -32768, 32767));
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_steady)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        estimate_t got;
        estimate_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_estimates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected beat %h", got);
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h actual %h", want, got);
                    end
                end
            end
        end
    end

    task automatic send_sample(input sample_t s);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_estimates.push_back(predict_estimate(s, refrigerant_sel));
        burst_left--;
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_estimates.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic select_refrigerant(input logic [1:0] sel);
        drain_pipeline();
        cfg_we <= 1'b1;
        cfg_data <= sel;
        @(posedge clk);
        cfg_we <= 1'b0;
        refrigerant_sel = sel;
        @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.displacement = (($urandom_range(0, 3) == 0) ? 16'($urandom) :
            16'($urandom_range(0, 3000)));
        s.speed = (($urandom_range(0, 3) == 0) ? 16'($urandom) :
            16'($urandom_range(0, 3000)));
        s.evap_temp = (($urandom_range(0, 4) == 0) ? 12'($urandom) :
            12'($urandom_range(0, 1400) - 500));
        s.cond_temp = (($urandom_range(0, 4) == 0) ? 12'($urandom) :
            12'($urandom_range(0, 1400) - 200));
        return s;
    endfunction

    task automatic test_field_extremes();
        send_sample('{12'sd0, 12'sd0, 16'd0, 16'd0});
        send_sample('{12'sd2000, -12'sd1000, 16'hFFFF, 16'hFFFF});
        send_sample('{-12'sd1000, 12'sd2000, 16'hFFFF, 16'hFFFF});
        send_sample('{12'sh7FF, 12'sh800, 16'd1000, 16'd1000});
        send_sample('{12'sh800, 12'sh7FF, 16'd500, 16'd40});
        send_sample('{12'sh7FF, 12'sh7FF, 16'd1, 16'hFFFF});
        send_sample('{12'sh800, 12'sh800, 16'hFFFF, 16'd1});
        send_sample('{12'sd400, -12'sd400, 16'd300, 16'd300});
        send_sample('{12'sd400, 12'sd967, 16'd300, 16'd300});
        send_sample('{12'sd400, 12'sd100, 16'd99, 16'd1});
    endtask

    task automatic test_table_points();
        for (int i = 0; i < TABLE_POINTS; i++)
            send_sample('{12'sd450, 12'(temp_at(refrigerant_sel, i) + i % 3 - 1),
                16'd2000, 16'd300});
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            rx_steady = (i % 200) < 30;
            send_sample(random_sample());
        end
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_table_points();
        select_refrigerant(REF_R32);
        test_table_points();
        test_random(300);
        select_refrigerant(REF_R410A);
        test_table_points();
        test_random(300);
        select_refrigerant(2'd3);
        test_field_extremes();
        test_random(300);
        select_refrigerant(REF_R290);
        test_random(400);
        select_refrigerant(REF_R32);
        test_random(500);
        drain_pipeline();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/core/rcpe_pkg.sv
rtl/core/refrigerant_cycle_power_estimator.sv
verif/refrigerant_cycle_power_estimator_test.sv
